[rtl/core/pesw_pkg.sv]
`timescale 1ns / 1ps
// Package for the polygon edge span walker: field widths, fixed-point
// constants and default parameter values. No dependencies.
package pesw_pkg;

   localparam int SLOPE_FRAC_BITS_DEF = 16;   // fractional bits of the inverse slope
   localparam int MAX_ROWS            = 64;   // rows at or above this are dropped

   localparam int X_W     = 12;               // vertex x, eighths of a pixel
   localparam int Y_W     = 9;                // vertex y, eighths of a row
   localparam int ROW_W   = 7;                // row index including the value 64
   localparam int OROW_W  = 6;                // row index on the result port
   localparam int CX_W    = 11;               // signed crossing x on the result port
   localparam int DIFF_W  = 11;               // signed row offset times eight
   localparam int HEAD_W  = 24;               // guard bits above the binary point
   localparam int SUB_FRAC = 3;               // vertex fractional bits

   localparam int CROSS_MAX = 1023;
   localparam int CROSS_MIN = -1024;

endpackage

[rtl/core/polygon_edge_span_walker.sv]
`timescale 1ns / 1ps
// A start request, an edge that crosses no row and an edge with no row below MAX_ROWS give
// no crossing and leave the walker idle. Any other line-to request runs 12+SLOPE_FRAC_BITS
// divide steps, a sign step, 11 multiply steps and a base step; the walk state then loads
// the crossings into the result register, one per cycle while the result side does not stall.
// Requests stall until the final crossing is loaded. Reset (synchronous, active high) clears
// the sequencer, result valid, point and mode.
module polygon_edge_span_walker #(
   parameter int SLOPE_FRAC_BITS = pesw_pkg::SLOPE_FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_cmd,
   input  logic [pesw_pkg::X_W-1:0]      req_pt_x,
   input  logic [pesw_pkg::Y_W-1:0]      req_pt_y,
   input  logic                          req_fill_clockwise,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [pesw_pkg::OROW_W-1:0]   rsp_row,
   output logic signed [pesw_pkg::CX_W-1:0] rsp_cross_x,
   output logic                          rsp_transition,
   output logic                          rsp_last
);
   import pesw_pkg::*;

   localparam int F   = SLOPE_FRAC_BITS;
   localparam int AW  = F + HEAD_W;          // datapath width
   localparam int QW  = X_W + F;             // dividend and quotient width
   localparam int CW  = $clog2(QW);          // step counter width
   localparam int YSW = Y_W + 1;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_DIV  = 6'b000010,
      ST_QNEG = 6'b000100,
      ST_MUL  = 6'b001000,
      ST_BASE = 6'b010000,
      ST_WALK = 6'b100000
   } state_type;

   state_type             state_ff, state_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [X_W-1:0]        cur_x_ff, cur_x_in;
   logic [Y_W-1:0]        cur_y_ff, cur_y_in;
   logic                  cw_mode_ff, cw_mode_in;
   logic [QW-1:0]         num_ff, num_in;
   logic [Y_W-1:0]        den_ff, den_in;
   logic [Y_W-1:0]        rem_ff, rem_in;
   logic                  qneg_ff, qneg_in;
   logic [AW-1:0]         inv_ff, inv_in;
   logic [AW-1:0]         mcand_ff, mcand_in;
   logic [DIFF_W-1:0]     mul_ff, mul_in;
   logic [AW-1:0]         acc_ff, acc_in;
   logic [AW-1:0]         base_ff, base_in;
   logic [AW-1:0]         x_ff, x_in;
   logic [ROW_W-1:0]      row_ff, row_in;
   logic [ROW_W-1:0]      stop_ff, stop_in;
   logic                  trans_ff, trans_in;
   logic                  out_valid_ff, out_valid_in;
   logic [OROW_W-1:0]     out_row_ff, out_row_in;
   logic [CX_W-1:0]       out_cx_ff, out_cx_in;
   logic                  out_trans_ff, out_trans_in;
   logic                  out_last_ff, out_last_in;

   // shared adder / subtractor
   logic [AW-1:0]         op_a, op_b, alu_sum;
   logic                  op_sub;

   // request decode
   logic                  accept;
   logic [YSW-1:0]        ysum_a, ysum_b;
   logic [ROW_W-1:0]      row_a, row_b, row_lo, row_hi, row_stop;
   logic signed [YSW-1:0] dy;
   logic signed [X_W:0]   dx;
   logic [Y_W-1:0]        dy_mag;
   logic [X_W-1:0]        dx_mag;
   logic [X_W:0]          cx_bias;
   logic signed [DIFF_W-1:0] row_off;
   logic                  walk_go;

   // division step
   logic [Y_W:0]          trial;

   // crossing
   logic signed [HEAD_W-1:0] x_int;
   logic [CX_W-1:0]       cx_sat;
   logic                  load_out;
   logic                  is_last;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   assign ysum_a  = {1'b0, cur_y_ff} + YSW'(4);
   assign ysum_b  = {1'b0, req_pt_y} + YSW'(4);
   assign row_a   = ysum_a[YSW-1:SUB_FRAC];
   assign row_b   = ysum_b[YSW-1:SUB_FRAC];
   assign dy      = $signed({1'b0, req_pt_y}) - $signed({1'b0, cur_y_ff});
   assign dx      = $signed({1'b0, req_pt_x}) - $signed({1'b0, cur_x_ff});
   assign dy_mag  = dy[YSW-1] ? Y_W'(-dy) : dy[Y_W-1:0];
   assign dx_mag  = dx[X_W]   ? X_W'(-dx) : dx[X_W-1:0];
   assign row_lo  = dy[YSW-1] ? row_b : row_a;
   assign row_hi  = dy[YSW-1] ? row_a : row_b;
   assign row_stop = (row_hi < ROW_W'(MAX_ROWS)) ? row_hi : ROW_W'(MAX_ROWS);
   assign walk_go = (row_a != row_b) && (row_lo < row_stop);
   assign row_off = $signed({1'b0, row_lo, {SUB_FRAC{1'b0}}})
                  - $signed({{(DIFF_W-Y_W){1'b0}}, cur_y_ff});
   // half-pixel rounding bias folded into the start x: (x + 4) << (F-3)
   assign cx_bias = {1'b0, cur_x_ff} + (X_W+1)'(4);

   assign trial = {rem_ff, num_ff[QW-1]};

   always_comb begin
      op_a   = '0;
      op_b   = '0;
      op_sub = 1'b0;
      case (state_ff)
         ST_DIV: begin
            op_a   = AW'(trial);
            op_b   = AW'(den_ff);
            op_sub = 1'b1;
         end
         ST_QNEG: begin
            op_b   = AW'(num_ff);
            op_sub = qneg_ff;
         end
         ST_MUL: begin
            op_a   = acc_ff;
            op_b   = mcand_ff;
            // the top bit of the row offset carries negative weight
            op_sub = (cnt_ff == '0);
         end
         ST_BASE: begin
            op_a = base_ff;
            op_b = AW'($signed(acc_ff) >>> SUB_FRAC);
         end
         ST_WALK: begin
            op_a = x_ff;
            op_b = inv_ff;
         end
         default: begin
            op_a = '0;
         end
      endcase
   end

   assign alu_sum = op_a + (op_b ^ {AW{op_sub}}) + AW'(op_sub);

   assign x_int = $signed(x_ff[AW-1:F]);
   always_comb begin
      if (x_int > HEAD_W'(CROSS_MAX)) begin
         cx_sat = CX_W'(CROSS_MAX);
      end else if (x_int < HEAD_W'(CROSS_MIN)) begin
         cx_sat = CX_W'(CROSS_MIN);
      end else begin
         cx_sat = x_int[CX_W-1:0];
      end
   end

   assign load_out = (state_ff == ST_WALK) && (!out_valid_ff || !rsp_stall);
   assign is_last  = ((row_ff + ROW_W'(1)) == stop_ff);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      cw_mode_in   = cw_mode_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      qneg_in      = qneg_ff;
      inv_in       = inv_ff;
      mcand_in     = mcand_ff;
      mul_in       = mul_ff;
      acc_in       = acc_ff;
      base_in      = base_ff;
      x_in         = x_ff;
      row_in       = row_ff;
      stop_in      = stop_ff;
      trans_in     = trans_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_row_in   = out_row_ff;
      out_cx_in    = out_cx_ff;
      out_trans_in = out_trans_ff;
      out_last_in  = out_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cur_x_in = req_pt_x;
               cur_y_in = req_pt_y;
               if (!req_cmd) begin
                  cw_mode_in = req_fill_clockwise;
               end else if (walk_go) begin
                  state_in = ST_DIV;
                  cnt_in   = CW'(QW - 1);
                  num_in   = {dx_mag, {F{1'b0}}};
                  den_in   = dy_mag;
                  rem_in   = '0;
                  qneg_in  = dx[X_W] ^ dy[YSW-1];
                  mul_in   = row_off;
                  base_in  = AW'({cx_bias, {(F-SUB_FRAC){1'b0}}});
                  row_in   = row_lo;
                  stop_in  = row_stop;
                  trans_in = !(!dy[YSW-1] && cw_mode_ff);
               end
            end
         end
         ST_DIV: begin
            // restore on a negative trial, shift the quotient bit in at the bottom
            if (alu_sum[AW-1]) begin
               rem_in = trial[Y_W-1:0];
            end else begin
               rem_in = alu_sum[Y_W-1:0];
            end
            num_in = {num_ff[QW-2:0], !alu_sum[AW-1]};
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == '0) begin
               state_in = ST_QNEG;
            end
         end
         ST_QNEG: begin
            inv_in   = alu_sum;
            mcand_in = alu_sum;
            acc_in   = '0;
            cnt_in   = CW'(DIFF_W - 1);
            state_in = ST_MUL;
         end
         ST_MUL: begin
            if (mul_ff[0]) begin
               acc_in = alu_sum;
            end
            mcand_in = {mcand_ff[AW-2:0], 1'b0};
            mul_in   = {1'b0, mul_ff[DIFF_W-1:1]};
            cnt_in   = cnt_ff - CW'(1);
            if (cnt_ff == '0) begin
               state_in = ST_BASE;
            end
         end
         ST_BASE: begin
            x_in     = alu_sum;
            state_in = ST_WALK;
         end
         ST_WALK: begin
            if (load_out) begin
               out_valid_in = 1'b1;
               out_row_in   = row_ff[OROW_W-1:0];
               out_cx_in    = cx_sat;
               out_trans_in = trans_ff;
               out_last_in  = is_last;
               x_in         = alu_sum;
               row_in       = row_ff + ROW_W'(1);
               if (is_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         cw_mode_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         cw_mode_ff   <= cw_mode_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff       <= cnt_in;
      num_ff       <= num_in;
      den_ff       <= den_in;
      rem_ff       <= rem_in;
      qneg_ff      <= qneg_in;
      inv_ff       <= inv_in;
      mcand_ff     <= mcand_in;
      mul_ff       <= mul_in;
      acc_ff       <= acc_in;
      base_ff      <= base_in;
      x_ff         <= x_in;
      row_ff       <= row_in;
      stop_ff      <= stop_in;
      trans_ff     <= trans_in;
      out_row_ff   <= out_row_in;
      out_cx_ff    <= out_cx_in;
      out_trans_ff <= out_trans_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_row        = out_row_ff;
   assign rsp_cross_x    = $signed(out_cx_ff);
   assign rsp_transition = out_trans_ff;
   assign rsp_last       = out_last_ff;

`ifndef SYNTHESIS
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (den_ff != '0))
      else $error("divide step with zero row span");

   a_div_to_sign: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && cnt_ff == '0) |=> (state_ff == ST_QNEG))
      else $error("divider did not hand over after its last step");

   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (row_ff < stop_ff))
      else $error("walk row reached its stop row");

   a_last_ends_walk: assert property (@(posedge clock) disable iff (reset)
      (load_out && is_last) |=> (state_ff == ST_IDLE && rsp_valid && rsp_last))
      else $error("final crossing did not end the edge");
`endif

endmodule
